// ===== src/pwg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_pkg: shared types, constants and cosine table for the wave generator
// Holds the field widths, register and waveform codes, the request record
// passed from the front end to the back end, and the quarter-wave cosine
// table built at elaboration with integer fixed-point arithmetic.
// ----------------------------------------------------------------------------
package pwg_pkg;

    // Field widths
    localparam int TABLE_BITS     = 10;
    localparam int PHASE_BITS     = 32;
    localparam int SAMPLE_BITS    = 16;
    localparam int AMP_BITS       = 15;
    localparam int KIND_BITS      = 2;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    // Table geometry: only one quarter of the cosine period is stored
    localparam int TABLE_SIZE   = 1 << TABLE_BITS;
    localparam int QUARTER      = TABLE_SIZE / 4;
    localparam int EIGHTH       = TABLE_SIZE / 8;
    localparam int QUARTER_BITS = TABLE_BITS - 2;
    localparam int ROM_BITS     = 16;
    localparam int ENTRY_BITS   = ROM_BITS + 1;
    localparam int PROD_BITS    = AMP_BITS + 1 + ENTRY_BITS;

    // Queue depths between the parts
    localparam int CMD_DEPTH     = 4;
    localparam int CMD_PTR_BITS  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_BITS  = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 3);

    // Waveform codes
    typedef enum logic [KIND_BITS-1:0] {
        WAVE_COS    = 2'd0,
        WAVE_SIN    = 2'd1,
        WAVE_SQUARE = 2'd2
    } wave_kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PHASE_STEP   = 4'd0,
        REG_PHASE_OFFSET = 4'd1,
        REG_AMPLITUDE    = 4'd2,
        REG_WAVE_KIND    = 4'd3
    } cfg_reg_t;

    localparam logic [AMP_BITS-1:0] AMP_RESET = {AMP_BITS{1'b1}};

    // Request from the front end to the back end
    typedef struct packed {
        logic                  valid;
        wave_kind_t            kind;
        logic [TABLE_BITS-1:0] idx;
    } cmd_t;

    // Fixed-point support for building the table (Q60)
    localparam logic [63:0] FX_ONE = 64'h1000_0000_0000_0000;

    typedef logic signed [ROM_BITS-1:0] quarter_rom_t [QUARTER];

    // (a * b) >> 60 from partial products, each truncated on its own
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] mid;
        ah  = a >> 32;
        al  = a & 64'hFFFF_FFFF;
        bh  = b >> 32;
        bl  = b & 64'hFFFF_FFFF;
        mid = ah * bl + al * bh;
        return ((ah * bh) << 4) + (mid >> 28) + ((al * bl) >> 60);
    endfunction

    // Truncating quotient by shift and subtract, used at elaboration only
    function automatic logic [63:0] fx_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/n) in Q60 by its alternating series
    function automatic logic [63:0] fx_atan_inv(input logic [63:0] n);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n2;
        logic [63:0] i;
        term = fx_div(FX_ONE, n);
        sum  = term;
        n2   = n * n;
        i    = 64'd1;
        while (term != '0)
        begin
            term = fx_div(term, n2);
            if (i[0])
                sum = sum - fx_div(term, 64'd2 * i + 64'd1);
            else
                sum = sum + fx_div(term, 64'd2 * i + 64'd1);
            i = i + 64'd1;
        end
        return sum;
    endfunction

    localparam logic [63:0] PI_Q60 = 64'd16 * fx_atan_inv(64'd5)
                                   - 64'd4 * fx_atan_inv(64'd239);

    // Taylor series of cos (odd = 0) or sin (odd = 1) for x up to pi/4
    function automatic logic [63:0] fx_trig(input logic [63:0] x, input logic odd);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] d;
        x2   = fx_mul(x, x);
        term = odd ? x : FX_ONE;
        sum  = term;
        d    = odd ? 64'd2 : 64'd1;
        for (int i = 1; i < 14; i++)
        begin
            term = fx_div(fx_mul(term, x2), d * (d + 64'd1));
            d    = d + 64'd2;
            if (i % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // round(32767 * cos(2*pi*m / TABLE_SIZE)) for m in the first quarter
    function automatic logic [ROM_BITS-1:0] quarter_entry(input int m);
        logic        use_sin;
        logic [63:0] j;
        logic [63:0] lowmask;
        logic [63:0] x;
        logic [63:0] v;
        logic [63:0] y;
        logic [63:0] r;
        use_sin = (m > EIGHTH);
        j       = use_sin ? 64'(QUARTER - m) : 64'(m);
        lowmask = (64'd1 << (TABLE_BITS - 1)) - 64'd1;
        x       = (PI_Q60 >> (TABLE_BITS - 1)) * j
                + (((PI_Q60 & lowmask) * j) >> (TABLE_BITS - 1));
        v       = fx_trig(x, use_sin);
        y       = (v >> 20) * 64'd32767;
        r       = (y + (64'd1 << 39)) >> 40;
        return r[ROM_BITS-1:0];
    endfunction

    function automatic quarter_rom_t build_quarter_rom();
        quarter_rom_t rom;
        for (int m = 0; m < QUARTER; m++)
        begin
            rom[m] = signed'(quarter_entry(m));
        end
        return rom;
    endfunction

    localparam quarter_rom_t COS_QUARTER = build_quarter_rom();

endpackage
`default_nettype wire

// ===== src/pwg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_front: request intake and phase accumulator
// Accepts a request, forms the sample phase from the accumulator and the
// offset, turns it into a table index and queues it for the back end.
// ----------------------------------------------------------------------------
module pwg_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             start_block,
    input  wire logic [pwg_pkg::PHASE_BITS-1:0]   phase_step,
    input  wire logic [pwg_pkg::PHASE_BITS-1:0]   phase_offset,
    input  wire pwg_pkg::wave_kind_t              wave_kind,
    output pwg_pkg::cmd_t                         cmd,
    input  wire logic                             cmd_pop
);
    import pwg_pkg::*;

    localparam logic [TABLE_BITS-1:0] QUARTER_IDX = TABLE_BITS'(QUARTER);

    logic [PHASE_BITS-1:0]   acc_reg;
    logic [PHASE_BITS-1:0]   acc_next;
    logic [PHASE_BITS-1:0]   acc_base;
    logic [PHASE_BITS-1:0]   phase_sum;
    logic [TABLE_BITS-1:0]   idx_new;
    logic                    accept;

    wave_kind_t              kind_mem_reg [CMD_DEPTH];
    logic [TABLE_BITS-1:0]   idx_mem_reg  [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg;
    logic [CMD_CNT_BITS-1:0] count_reg;
    logic [CMD_CNT_BITS-1:0] count_next;

    assign full   = (count_reg == CMD_CNT_BITS'(CMD_DEPTH));
    assign accept = push && !full;

    // Form the sample phase; sine steps back a quarter turn in the index
    always_comb
    begin
        acc_base  = start_block ? '0 : acc_reg;
        phase_sum = acc_base + phase_offset;
        acc_next  = acc_base + phase_step;
        idx_new   = phase_sum[PHASE_BITS-1 -: TABLE_BITS];
        if (wave_kind == WAVE_SIN)
            idx_new = idx_new - QUARTER_IDX;
    end

    // Advance the accumulator on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (accept)
            acc_reg <= acc_next;
    end

    // Queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (accept && !cmd_pop)
            count_next = count_reg + CMD_CNT_BITS'(1);
        else if (!accept && cmd_pop)
            count_next = count_reg - CMD_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_BITS'(1);
            if (cmd_pop)
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_BITS'(1);
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_mem_reg[wr_ptr_reg] <= wave_kind;
            idx_mem_reg[wr_ptr_reg]  <= idx_new;
        end
    end

    // Present the oldest request
    always_comb
    begin
        cmd.valid = (count_reg != '0);
        cmd.kind  = kind_mem_reg[rd_ptr_reg];
        cmd.idx   = idx_mem_reg[rd_ptr_reg];
    end

endmodule
`default_nettype wire

// ===== src/pwg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwg_back: table lookup, scaling and result queue
// Looks up the cosine entry by quarter-wave symmetry, or takes a unit step
// for square, scales it by the amplitude, and queues the sample. Issues a
// request only when the result queue has room for everything in flight.
// ----------------------------------------------------------------------------
module pwg_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pwg_pkg::cmd_t                       cmd,
    output logic                                     cmd_pop,
    input  wire logic [pwg_pkg::AMP_BITS-1:0]        amplitude,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [pwg_pkg::SAMPLE_BITS-1:0]   sample
);
    import pwg_pkg::*;

    localparam logic signed [ENTRY_BITS-1:0] SQUARE_UNIT = ENTRY_BITS'(1 << AMP_BITS);

    logic [1:0]                    quad;
    logic [QUARTER_BITS-1:0]       rem;
    logic [QUARTER_BITS-1:0]       rom_addr;
    logic                          mirror;
    logic                          negate;
    logic signed [ENTRY_BITS-1:0]  mag;
    logic signed [ENTRY_BITS-1:0]  entry_next;
    logic                          issue;
    logic [OUT_CNT_BITS-1:0]       occupancy;

    logic                          s1_valid_reg;
    logic signed [ENTRY_BITS-1:0]  s1_entry_reg;
    logic                          s2_valid_reg;
    logic signed [PROD_BITS-1:0]   s2_prod_reg;
    logic signed [PROD_BITS-1:0]   s2_prod_next;

    logic signed [SAMPLE_BITS-1:0] out_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0]       out_wr_reg;
    logic [OUT_PTR_BITS-1:0]       out_rd_reg;
    logic [OUT_CNT_BITS-1:0]       out_count_reg;
    logic [OUT_CNT_BITS-1:0]       out_count_next;
    logic                          out_take;

    // Issue only when the result queue can hold all requests in flight
    assign occupancy = out_count_reg + OUT_CNT_BITS'(s1_valid_reg)
                     + OUT_CNT_BITS'(s2_valid_reg);
    assign issue     = cmd.valid && (occupancy < OUT_CNT_BITS'(OUT_DEPTH));
    assign cmd_pop   = issue;

    // Fold the index into the first quarter
    always_comb
    begin
        quad     = cmd.idx[TABLE_BITS-1 -: 2];
        rem      = cmd.idx[QUARTER_BITS-1:0];
        mirror   = quad[0];
        negate   = quad[0] ^ quad[1];
        rom_addr = mirror ? (QUARTER_BITS'(0) - rem) : rem;
        if (mirror && (rem == '0))
            mag = '0;
        else
            mag = ENTRY_BITS'(COS_QUARTER[rom_addr]);
    end

    // Select the unscaled entry; square uses plus or minus one in Q15
    always_comb
    begin
        unique case (cmd.kind) inside
            WAVE_COS, WAVE_SIN:
                entry_next = negate ? -mag : mag;
            WAVE_SQUARE:
                entry_next = cmd.idx[TABLE_BITS-1] ? -SQUARE_UNIT : SQUARE_UNIT;
            default:
                entry_next = '0;
        endcase
    end

    // Scale by the amplitude
    assign s2_prod_next = PROD_BITS'(signed'({1'b0, amplitude})) * PROD_BITS'(s1_entry_reg);

    // Advance the lookup and multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_entry_reg <= entry_next;
        s2_prod_reg  <= s2_prod_next;
    end

    // Result queue
    assign empty    = (out_count_reg == '0);
    assign out_take = pop && !empty;
    assign sample   = out_mem_reg[out_rd_reg];

    always_comb
    begin
        out_count_next = out_count_reg;
        if (s2_valid_reg && !out_take)
            out_count_next = out_count_reg + OUT_CNT_BITS'(1);
        else if (!s2_valid_reg && out_take)
            out_count_next = out_count_reg - OUT_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            out_count_reg <= out_count_next;
            if (s2_valid_reg)
                out_wr_reg <= out_wr_reg + OUT_PTR_BITS'(1);
            if (out_take)
                out_rd_reg <= out_rd_reg + OUT_PTR_BITS'(1);
        end
    end

    // Drop the Q15 fraction with an arithmetic shift
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            out_mem_reg[out_wr_reg] <= s2_prod_reg[AMP_BITS +: SAMPLE_BITS];
    end

endmodule
`default_nettype wire

// ===== src/periodic_wave_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_wave_generator: numerically controlled oscillator
// Phase accumulator with cosine, sine and square output, scaled by a
// programmable amplitude.
// ----------------------------------------------------------------------------
// Each request pushed in yields one signed Q1.15 sample; a request with
// start_block set clears the phase accumulator first. The sample uses the
// accumulator value before it advances by phase_step. One request is taken
// every clock and one sample leaves every clock when pop is held high; a
// sample passes the request queue, the table lookup stage, the multiply
// stage and the result queue before it can be popped. The front end
// advances its accumulator once per request. The cosine table holds one quarter
// wave and is built at elaboration. Registers: 0 phase_step, 1 phase_offset,
// 2 amplitude (reset 32767), 3 wave_kind (0 cosine, 1 sine, 2 square, 3
// gives zero); write them only while the block is idle.
// ----------------------------------------------------------------------------
module periodic_wave_generator (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic                                   start_block,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [pwg_pkg::SAMPLE_BITS-1:0]      sample,
    input  wire logic                                   cfg_write,
    input  wire logic [pwg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [pwg_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import pwg_pkg::*;

    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [PHASE_BITS-1:0] phase_offset_reg;
    logic [AMP_BITS-1:0]   amplitude_reg;
    wave_kind_t            wave_kind_reg;
    cmd_t                  cmd;
    logic                  cmd_pop;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            phase_offset_reg <= '0;
            amplitude_reg    <= AMP_RESET;
            wave_kind_reg    <= WAVE_COS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[PHASE_BITS-1:0];
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_data[PHASE_BITS-1:0];
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[AMP_BITS-1:0];
                REG_WAVE_KIND:    wave_kind_reg    <= wave_kind_t'(cfg_data[KIND_BITS-1:0]);
                default:          ;
            endcase
        end
    end

    // Front end: intake and phase
    pwg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .start_block  (start_block),
        .phase_step   (phase_step_reg),
        .phase_offset (phase_offset_reg),
        .wave_kind    (wave_kind_reg),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    // Back end: lookup, scale, result queue
    pwg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .amplitude (amplitude_reg),
        .empty     (empty),
        .pop       (pop),
        .sample    (sample)
    );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the periodic wave generator
// Drives tick requests through the push/full port and pulls samples through
// empty/pop. A scoreboard carries its own phase accumulator, register copies
// and cosine table, predicts every sample and compares it in order. Register
// settings change between phases while the block is drained, and both sides
// idle at random under four profiles that the phases take in turn.
// ----------------------------------------------------------------------------
module tb;

    import pwg_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_TICKS = 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_TICKS = 150;

    // Waveform code with no waveform behind it: the block outputs zero
    localparam logic [KIND_BITS-1:0]      WAVE_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] LAST_INDEX  = '1;
    localparam logic [CFG_DATA_BITS-1:0]  ALL_ONES    = '1;
    localparam logic [PHASE_BITS-1:0]     QUARTER_TURN = 32'h4000_0000;
    localparam logic [PHASE_BITS-1:0]     HALF_TURN    = 32'h8000_0000;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each sample from its own copy of the oscillator
    // ------------------------------------------------------------------------
    class nco_scoreboard;
        int                                 cos_table [TABLE_SIZE];
        logic signed [SAMPLE_BITS-1:0]      expected_samples [$];
        logic        [PHASE_BITS-1:0]       accumulator;
        logic        [PHASE_BITS-1:0]       step;
        logic        [PHASE_BITS-1:0]       offset;
        logic        [AMP_BITS-1:0]         amp;
        logic        [KIND_BITS-1:0]        kind;
        int                                 errors;

        function new();
            accumulator = '0;
            step        = '0;
            offset      = '0;
            amp         = AMP_RESET;
            kind        = WAVE_COS;
            errors      = 0;
            build_table();
        endfunction

        // (a * b) >> 60 in Q60, carries of the partial products dropped
        function bit [63:0] q60_mul(input bit [63:0] a, input bit [63:0] b);
            bit [63:0] ah;
            bit [63:0] al;
            bit [63:0] bh;
            bit [63:0] bl;
            bit [63:0] mid;
            ah  = a >> 32;
            al  = a & 64'hFFFF_FFFF;
            bh  = b >> 32;
            bl  = b & 64'hFFFF_FFFF;
            mid = ah * bl + al * bh;
            return ((ah * bh) << 4) + (mid >> 28) + ((al * bl) >> 60);
        endfunction

        // atan(1/n) in Q60 by its alternating series
        function bit [63:0] atan_recip(input bit [63:0] n);
            bit [63:0] term;
            bit [63:0] sum;
            bit [63:0] n2;
            bit [63:0] i;
            term = (64'd1 << 60) / n;
            sum  = term;
            n2   = n * n;
            i    = 1;
            while (term != 0)
            begin
                term = term / n2;
                if (i[0])
                    sum = sum - term / (2 * i + 1);
                else
                    sum = sum + term / (2 * i + 1);
                i = i + 1;
            end
            return sum;
        endfunction

        // Taylor series of cos or sin (odd set) for x up to pi/4 in Q60
        function bit [63:0] taylor(input bit [63:0] x, input bit odd);
            bit [63:0] x2;
            bit [63:0] term;
            bit [63:0] sum;
            bit [63:0] d;
            x2   = q60_mul(x, x);
            term = odd ? x : (64'd1 << 60);
            sum  = term;
            d    = odd ? 64'd2 : 64'd1;
            for (int i = 1; i < 14; i++)
            begin
                term = q60_mul(term, x2) / (d * (d + 1));
                d    = d + 2;
                if (i % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            return sum;
        endfunction

        // round(32767 * cos(2*pi*m / TABLE_SIZE)) within the first quarter
        function int quarter_value(input bit [63:0] pi_q60, input int m);
            bit        near_top;
            bit [63:0] j;
            bit [63:0] lowmask;
            bit [63:0] x;
            bit [63:0] y;
            near_top = (m > TABLE_SIZE / 8);
            j        = near_top ? 64'(TABLE_SIZE / 4 - m) : 64'(m);
            lowmask  = (64'd1 << (TABLE_BITS - 1)) - 1;
            x        = (pi_q60 >> (TABLE_BITS - 1)) * j
                     + (((pi_q60 & lowmask) * j) >> (TABLE_BITS - 1));
            y        = (taylor(x, near_top) >> 20) * 64'd32767;
            return int'((y + (64'd1 << 39)) >> 40);
        endfunction

        // Fill the full-period table by symmetry
        function void build_table();
            bit [63:0] pi_q60;
            pi_q60 = 16 * atan_recip(5) - 4 * atan_recip(239);
            for (int k = 0; k < TABLE_SIZE; k++)
            begin
                if (k <= TABLE_SIZE / 4)
                    cos_table[k] = quarter_value(pi_q60, k);
                else if (k < TABLE_SIZE / 2)
                    cos_table[k] = -quarter_value(pi_q60, TABLE_SIZE / 2 - k);
                else if (k <= 3 * TABLE_SIZE / 4)
                    cos_table[k] = -quarter_value(pi_q60, k - TABLE_SIZE / 2);
                else
                    cos_table[k] = quarter_value(pi_q60, TABLE_SIZE - k);
            end
        endfunction

        // Track a register write; unknown indexes are dropped
        function void write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0]  data);
            case (idx)
                REG_PHASE_STEP:   step   = data[PHASE_BITS-1:0];
                REG_PHASE_OFFSET: offset = data[PHASE_BITS-1:0];
                REG_AMPLITUDE:    amp    = data[AMP_BITS-1:0];
                REG_WAVE_KIND:    kind   = data[KIND_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Predict the sample of one accepted tick and advance the phase
        function void note_tick(input logic start);
            logic [PHASE_BITS-1:0]         phase;
            logic signed [SAMPLE_BITS-1:0] value;
            int                            prod;
            if (start)
                accumulator = '0;
            phase       = accumulator + offset;
            accumulator = accumulator + step;
            if (kind == WAVE_SIN)
                phase = phase - QUARTER_TURN;
            if (kind == WAVE_COS || kind == WAVE_SIN)
            begin
                prod  = int'(amp) * cos_table[phase[PHASE_BITS-1 -: TABLE_BITS]];
                value = SAMPLE_BITS'(prod >>> 15);
            end
            else if (kind == WAVE_SQUARE)
                value = phase[PHASE_BITS-1] ? -SAMPLE_BITS'(amp) : SAMPLE_BITS'(amp);
            else
                value = '0;
            expected_samples.push_back(value);
        endfunction

        // Compare a popped sample with the oldest prediction
        function void check_sample(input logic signed [SAMPLE_BITS-1:0] got);
            logic signed [SAMPLE_BITS-1:0] want;
            if (expected_samples.size() == 0)
            begin
                $display("%0t: sample %0d popped with none expected", $time, got);
                errors++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got !== want)
                begin
                    $display("%0t: sample mismatch, expected %0d, got %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int waiting();
            return expected_samples.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              push;
    logic                              full;
    logic                              start_block;
    logic                              empty;
    logic                              pop = 1'b0;
    logic signed [SAMPLE_BITS-1:0]     sample;
    logic                              cfg_write;
    logic [CFG_INDEX_BITS-1:0]         cfg_index;
    logic [CFG_DATA_BITS-1:0]          cfg_data;

    int                                idle_pct;
    int                                stall_pct;
    int                                cycles = 0;
    nco_scoreboard                     board;

    periodic_wave_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .start_block (start_block),
        .empty       (empty),
        .pop         (pop),
        .sample      (sample),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Receiver: pop at random according to the current stall rate
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: track writes, note accepted requests, check popped samples
    always @(posedge clk)
    begin
        if (cfg_write)
            board.write_reg(cfg_index, cfg_data);
        if (push && !full)
            board.note_tick(start_block);
        if (pop && !empty)
            board.check_sample(sample);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Hold push low at random, as often as the idle rate asks
    task automatic sender_pause();
        if ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Present one request and wait until it is taken
    task automatic send_tick(input logic start);
        sender_pause();
        push        <= 1'b1;
        start_block <= start;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Send n requests, only the first with the given start flag
    task automatic run_ticks(input int n, input logic first_start);
        for (int i = 0; i < n; i++)
            send_tick(i == 0 ? first_start : 1'b0);
    endtask

    // Drop push and wait until every predicted sample has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (board.waiting() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0]  data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write all four registers, then release the write enable
    task automatic configure(input logic [CFG_DATA_BITS-1:0] step_data,
                             input logic [CFG_DATA_BITS-1:0] offset_data,
                             input logic [CFG_DATA_BITS-1:0] amp_data,
                             input logic [CFG_DATA_BITS-1:0] kind_data);
        write_reg(REG_PHASE_STEP, step_data);
        write_reg(REG_PHASE_OFFSET, offset_data);
        write_reg(REG_AMPLITUDE, amp_data);
        write_reg(REG_WAVE_KIND, kind_data);
        cfg_write <= 1'b0;
    endtask

    // Pick the idling profile of a phase
    task automatic set_profile(input int phase_no);
        case (phase_no % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 34; stall_pct = 34; end
        endcase
    endtask

    // One phase with random settings and random requests
    task automatic random_phase(input int n);
        logic [CFG_DATA_BITS-1:0] step_data;
        logic [CFG_DATA_BITS-1:0] offset_data;
        logic [CFG_DATA_BITS-1:0] amp_data;
        logic [AMP_BITS-1:0]      amp_value;
        case ($urandom_range(4))
            0: step_data = '0;
            1: step_data = ALL_ONES;
            2: step_data = $urandom_range(0, 1 << 24);
            default: step_data = $urandom;
        endcase
        case ($urandom_range(3))
            0: offset_data = '0;
            1: offset_data = ALL_ONES;
            default: offset_data = $urandom;
        endcase
        case ($urandom_range(3))
            0: amp_value = '0;
            1: amp_value = '1;
            default: amp_value = AMP_BITS'($urandom);
        endcase
        amp_data = {17'($urandom), amp_value};
        if ($urandom_range(2) == 0)
            write_reg(CFG_INDEX_BITS'($urandom_range(REG_WAVE_KIND + 1, LAST_INDEX)),
                      $urandom);
        configure(step_data, offset_data, amp_data,
                  {30'($urandom), 2'($urandom_range(WAVE_COS, WAVE_UNUSED))});
        for (int i = 0; i < n; i++)
            send_tick($urandom_range(15) == 0);
    endtask

    // Stimulus
    initial
    begin
        board       = new();
        idle_pct    = 0;
        stall_pct   = 0;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        start_block <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full-scale cosine at a standing phase
        set_profile(0);
        run_ticks(2, 1'b1);
        drain();

        // Quarter-turn steps hit 0, 90, 180 and 270 degrees of a cosine
        set_profile(1);
        configure(QUARTER_TURN, '0, 32'h0000_7FFF, CFG_DATA_BITS'(WAVE_COS));
        run_ticks(5, 1'b1);
        drain();

        // Same steps on a sine; upper data bits of amplitude and kind set
        set_profile(2);
        configure(QUARTER_TURN, '0, ALL_ONES, {30'h3FFF_FFFF, WAVE_SIN});
        run_ticks(5, 1'b1);
        drain();

        // Writes to unknown indexes are ignored; square at the wrap point
        set_profile(3);
        write_reg(LAST_INDEX, ALL_ONES);
        write_reg(CFG_INDEX_BITS'(REG_WAVE_KIND + 1), $urandom);
        configure(HALF_TURN, ALL_ONES, 32'h0001_2345, CFG_DATA_BITS'(WAVE_SQUARE));
        run_ticks(4, 1'b1);
        drain();

        // Unused waveform code, accumulator wrapping every tick
        set_profile(0);
        configure(ALL_ONES, ALL_ONES, 32'h0000_7FFF, CFG_DATA_BITS'(WAVE_UNUSED));
        run_ticks(3, 1'b0);
        send_tick(1'b1);
        drain();

        // Zero amplitude
        set_profile(1);
        configure(32'h0123_4567, HALF_TURN, 32'hFFFF_8000, CFG_DATA_BITS'(WAVE_COS));
        run_ticks(2, 1'b0);
        drain();

        // Random phases, each with its own settings and idling profile
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_profile(p);
            random_phase(PHASE_TICKS);
            drain();
        end

        // Let the pipeline settle, then report
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.waiting() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
